FILE: src/lesf_pkg.sv
// Shared widths and register map of the largest empty square finder.
package lesf_pkg;

  // Result field widths
  localparam int unsigned SizeW = 11;
  localparam int unsigned PosW  = 10;

  // Configuration register field width and bus widths
  localparam int unsigned DimW   = 11;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // Largest grid dimension the 11-bit registers can express
  localparam int unsigned DimMax = 2047;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_e;

endpackage

FILE: src/lesf_if.sv
// Stream interfaces for grid cells and square results.
interface lesf_cell_if;
  import lesf_pkg::*;
  logic valid;
  logic ready;
  logic is_obstacle;

  modport source (output valid, output is_obstacle, input ready);
  modport sink   (input valid, input is_obstacle, output ready);
endinterface

interface lesf_result_if;
  import lesf_pkg::*;
  logic            valid;
  logic            ready;
  logic [SizeW-1:0] square_size;
  logic [PosW-1:0]  top_row;
  logic [PosW-1:0]  left_col;
  logic            found;

  modport source (output valid, output square_size, output top_row, output left_col,
                  output found, input ready);
  modport sink   (input valid, input square_size, input top_row, input left_col,
                  input found, output ready);
endinterface

FILE: src/largest_empty_square_finder.sv
// Top level: raster-order maximal free square search over a line store.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------------
//  cell_i    | in  | valid/ready        | is_obstacle
//  result_o  | out | valid/ready        | square_size, top_row, left_col, found
//  apb       | in  | psel/penable/pready| grid_rows @0x0, grid_cols @0x4 (11 bits)
//
// One cell per cycle while input is not stalled. A cell reads its upper neighbor from
// the line store at acceptance and is resolved from the stage-1 registers, when the
// line store is written back; a same-column write landing with the read is forwarded.
// The result leaves from an output register, loaded when the last cell of a grid
// resolves in stage 1; cells keep flowing while it waits, and input stalls only when the
// last cell of the next grid finds that register still occupied.
// Reset is asynchronous, active low; the line store needs no clearing.
module largest_empty_square_finder
  import lesf_pkg::*;
#(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lesf_cell_if.sink        cell_i,
  lesf_result_if.source    result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Effective limits: the registers cannot exceed DimMax
  localparam int unsigned RowLim = (MAX_ROWS > DimMax) ? DimMax : MAX_ROWS;
  localparam int unsigned ColLim = (MAX_COLS > DimMax) ? DimMax : MAX_COLS;
  localparam int unsigned RW     = (RowLim > 1) ? $clog2(RowLim) : 1;
  localparam int unsigned CW     = (ColLim > 1) ? $clog2(ColLim) : 1;

  // Configuration registers
  logic [DimW-1:0] rows_q, cols_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(1);
      cols_q <= DimW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_GRID_ROWS: rows_q <= pwdata[DimW-1:0];
        REG_GRID_COLS: cols_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_GRID_ROWS: prdata = DataW'(rows_q);
      REG_GRID_COLS: prdata = DataW'(cols_q);
      default:       prdata = '0;
    endcase
  end

  // Clamp dimensions and form the last index of each
  logic [DimW-1:0] rows_last, cols_last;

  always_comb begin
    if (rows_q == '0)                  rows_last = '0;
    else if (rows_q > DimW'(RowLim))   rows_last = DimW'(RowLim - 1);
    else                               rows_last = rows_q - DimW'(1);
    if (cols_q == '0)                  cols_last = '0;
    else if (cols_q > DimW'(ColLim))   cols_last = DimW'(ColLim - 1);
    else                               cols_last = cols_q - DimW'(1);
  end

  // Stage-1 and output control
  logic            s1_valid_q, s1_obst_q, s1_eor_q, s1_eog_q;
  logic [RW-1:0]   s1_row_q;
  logic [CW-1:0]   s1_col_q;
  logic            s1_fire, s1_go, cell_fire, out_free;
  logic            res_valid_q;

  assign out_free  = !res_valid_q || result_o.ready;
  assign s1_go     = !s1_eog_q || out_free;
  assign s1_fire   = s1_valid_q && s1_go;
  assign cell_i.ready = !s1_valid_q || s1_go;
  assign cell_fire = cell_i.valid && cell_i.ready;

  // Raster position of the next cell
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          at_eor, at_eog;

  assign at_eor = (DimW'(col_q) == cols_last);
  assign at_eog = at_eor && (DimW'(row_q) == rows_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cell_fire) begin
      if (!at_eor) begin
        col_q <= col_q + CW'(1);
      end else begin
        col_q <= '0;
        row_q <= at_eog ? '0 : row_q + RW'(1);
      end
    end
  end

  // Line store: read at acceptance, written when stage 1 resolves
  logic [SizeW-1:0] line_mem [ColLim];
  logic [SizeW-1:0] rd_q, fwd_val_q, cell_size;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_col_q] <= cell_size;
    end
    if (cell_fire) begin
      rd_q <= line_mem[col_q];
    end
  end

  // Forward a same-column write that lands with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (cell_fire) begin
      fwd_q <= s1_fire && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_fire) begin
      fwd_val_q <= cell_size;
    end
  end

  // Stage-1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_eor_q   <= 1'b0;
      s1_eog_q   <= 1'b0;
    end else if (cell_fire) begin
      s1_valid_q <= 1'b1;
      s1_eor_q   <= at_eor;
      s1_eog_q   <= at_eog;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
      s1_eog_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_fire) begin
      s1_obst_q <= cell_i.is_obstacle;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
    end
  end

  // Resolve the cell: min of neighbors plus one, or zero for an obstacle
  logic [SizeW-1:0] left_q, diag_q, up_val, min_ul, min_all;

  always_comb begin
    up_val    = (s1_row_q != '0) ? (fwd_q ? fwd_val_q : rd_q) : '0;
    min_ul    = (up_val < left_q) ? up_val : left_q;
    min_all   = (min_ul < diag_q) ? min_ul : diag_q;
    cell_size = s1_obst_q ? '0 : min_all + SizeW'(1);
  end

  // Candidate corner and the tie-break against the best so far
  logic [SizeW-1:0] best_size_q, nb_size;
  logic [RW-1:0]    best_row_q, nb_row, cand_row;
  logic [CW-1:0]    best_col_q, nb_col, cand_col;
  logic             take;

  always_comb begin
    cand_row = RW'(SizeW'(s1_row_q) + SizeW'(1) - cell_size);
    cand_col = CW'(SizeW'(s1_col_q) + SizeW'(1) - cell_size);
    take = (cell_size != '0) &&
           ((cell_size > best_size_q) ||
            ((cell_size == best_size_q) &&
             ((cand_row < best_row_q) ||
              ((cand_row == best_row_q) && (cand_col < best_col_q)))));
    nb_size = take ? cell_size : best_size_q;
    nb_row  = take ? cand_row  : best_row_q;
    nb_col  = take ? cand_col  : best_col_q;
  end

  // Neighbor and best-square state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (cfg_wr) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_fire) begin
      left_q <= s1_eor_q ? '0 : cell_size;
      diag_q <= s1_eor_q ? '0 : up_val;
      if (s1_eog_q) begin
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_size_q <= nb_size;
        best_row_q  <= nb_row;
        best_col_q  <= nb_col;
      end
    end
  end

  // Output register: load at end of grid, drop once taken
  logic [SizeW-1:0] res_size_q;
  logic [PosW-1:0]  res_row_q, res_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire && s1_eog_q) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_eog_q) begin
      res_size_q <= nb_size;
      res_row_q  <= PosW'(nb_row);
      res_col_q  <= PosW'(nb_col);
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.square_size = res_size_q;
  assign result_o.top_row     = res_row_q;
  assign result_o.left_col    = res_col_q;
  assign result_o.found       = (res_size_q != '0);

  // Checks on pipeline and result consistency
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_eog_q) |-> out_free)
    else $error("result register overwritten while occupied");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> (cell_size <= SizeW'(s1_row_q) + SizeW'(1) &&
                 cell_size <= SizeW'(s1_col_q) + SizeW'(1)))
    else $error("square larger than its position allows");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q)))
    else $error("stalled cell lost from stage 1");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_eog_q) |=> (best_size_q == '0))
    else $error("best square not cleared after grid end");

endmodule

FILE: sim/largest_empty_square_finder_tb.sv
// Self-checking testbench for the largest empty square finder: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module largest_empty_square_finder_tb;
  import lesf_pkg::*;

  localparam int unsigned MaxCols   = 1024;
  localparam int unsigned MaxRows   = 1024;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned DrainWait = 8;
  localparam int unsigned RandCells = 370;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic             found;
  } square_t;

  typedef struct {
    logic obstacle;
    bit   drain_first;
  } cell_item_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  lesf_cell_if   cell_if ();
  lesf_result_if result_if ();

  largest_empty_square_finder #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Cells waiting to be offered and squares waiting to come out
  cell_item_t pending_cells[$];
  square_t    square_q[$];
  int unsigned error_count = 0;

  // Stimulus controls seen by the driver and receiver
  bit          quiet = 1'b0;
  int unsigned hold_req = 0;

  // Predictor state and its copy of the registers
  logic [DimW-1:0]  rows_reg;
  logic [DimW-1:0]  cols_reg;
  logic [SizeW-1:0] line_sizes [MaxCols];
  logic [SizeW-1:0] left_sz;
  logic [SizeW-1:0] diag_sz;
  logic [SizeW-1:0] best_sz;
  logic [PosW-1:0]  row_pos;
  logic [PosW-1:0]  col_pos;
  logic [PosW-1:0]  best_row;
  logic [PosW-1:0]  best_col;

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned fold_dim(logic [DimW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic restart_scan();
    left_sz  = '0;
    diag_sz  = '0;
    row_pos  = '0;
    col_pos  = '0;
    best_sz  = '0;
    best_row = '0;
    best_col = '0;
  endtask

  // Advance the square search by one accepted cell
  task automatic scan_cell(input logic obstacle);
    int unsigned rows_n, cols_n, up, lf, dg, m, sz, tr, tc;
    square_t     sq;
    rows_n = fold_dim(rows_reg, MaxRows);
    cols_n = fold_dim(cols_reg, MaxCols);
    up = 0;
    lf = 0;
    dg = 0;
    if (row_pos != 0) begin
      up = line_sizes[col_pos];
      if (col_pos != 0) dg = diag_sz;
    end
    if (col_pos != 0) lf = left_sz;
    m  = (up < lf) ? up : lf;
    m  = (m < dg) ? m : dg;
    sz = obstacle ? 0 : m + 1;
    diag_sz = SizeW'(up);
    line_sizes[col_pos] = SizeW'(sz);
    left_sz = SizeW'(sz);
    // Keep the biggest square, earliest top-left corner on ties
    if (sz > 0) begin
      tr = row_pos + 1 - sz;
      tc = col_pos + 1 - sz;
      if (sz > best_sz || (sz == best_sz && (tr < best_row ||
                                             (tr == best_row && tc < best_col)))) begin
        best_sz  = SizeW'(sz);
        best_row = PosW'(tr);
        best_col = PosW'(tc);
      end
    end
    if (col_pos + 1 < cols_n) begin
      col_pos = col_pos + PosW'(1);
    end else begin
      col_pos = '0;
      left_sz = '0;
      diag_sz = '0;
      if (row_pos + 1 < rows_n) begin
        row_pos = row_pos + PosW'(1);
      end else begin
        sq.size  = best_sz;
        sq.row   = best_row;
        sq.col   = best_col;
        sq.found = (best_sz != 0);
        square_q.push_back(sq);
        restart_scan();
      end
    end
  endtask

  // Cell driver: hold a cell until taken, idle in bursts, honor drain points
  int unsigned send_gap = 0;
  int unsigned send_pct = 0;
  logic [6:0]  send_tick = '0;

  always @(posedge clk_i) begin : drive_cells
    cell_item_t item;
    send_tick <= send_tick + 7'd1;
    if (send_tick == '0) send_pct <= pick_idle_pct();
    if (!rst_ni) begin
      cell_if.valid       <= 1'b0;
      cell_if.is_obstacle <= 1'b0;
    end else if (cell_if.valid && !cell_if.ready) begin
      // hold the offered cell
    end else if (send_gap > 0) begin
      send_gap      <= send_gap - 1;
      cell_if.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < send_pct) begin
      send_gap      <= $urandom_range(1, 18) - 1;
      cell_if.valid <= 1'b0;
    end else if (pending_cells.size() != 0 &&
                 !(pending_cells[0].drain_first && square_q.size() != 0)) begin
      item                 = pending_cells.pop_front();
      cell_if.valid       <= 1'b1;
      cell_if.is_obstacle <= item.obstacle;
    end else begin
      cell_if.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  int unsigned recv_gap = 0;
  int unsigned recv_pct = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  logic [6:0]  recv_tick = '0;

  always @(posedge clk_i) begin
    recv_tick <= recv_tick + 7'd1;
    if (recv_tick == '0) recv_pct <= pick_idle_pct();
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen       <= hold_req;
      hold_left       <= LongHold;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap        <= recv_gap - 1;
      result_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < recv_pct) begin
      recv_gap        <= $urandom_range(1, 18) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted cell, check each accepted result
  always @(posedge clk_i) begin : watch_streams
    square_t want;
    if (rst_ni) begin
      if (cell_if.valid && cell_if.ready) scan_cell(cell_if.is_obstacle);
      if (result_if.valid && result_if.ready) begin
        if (square_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result size %0d row %0d col %0d found %0b", $time,
                   result_if.square_size, result_if.top_row, result_if.left_col,
                   result_if.found);
        end else begin
          want = square_q.pop_front();
          if (result_if.square_size !== want.size) begin
            error_count++;
            $display("%0t: square_size expected %0d actual %0d", $time, want.size,
                     result_if.square_size);
          end
          if (result_if.top_row !== want.row) begin
            error_count++;
            $display("%0t: top_row expected %0d actual %0d", $time, want.row,
                     result_if.top_row);
          end
          if (result_if.left_col !== want.col) begin
            error_count++;
            $display("%0t: left_col expected %0d actual %0d", $time, want.col,
                     result_if.left_col);
          end
          if (result_if.found !== want.found) begin
            error_count++;
            $display("%0t: found expected %0b actual %0b", $time, want.found,
                     result_if.found);
          end
        end
      end
    end
  end

  // Write one dimension register, then read it back
  task automatic set_dim(input reg_idx_e idx, input logic [DimW-1:0] val);
    logic [DataW-1:0] word;
    word = $urandom();
    word[DimW-1:0] = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_GRID_ROWS) rows_reg = val;
    else cols_reg = val;
    restart_scan();
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(val)) begin
      error_count++;
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, val,
               prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until no cell is queued or offered and no result is outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || cell_if.valid || square_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic push_cells(input int unsigned n, input int unsigned pct,
                            input bit drain_first);
    cell_item_t item;
    for (int unsigned i = 0; i < n; i++) begin
      item.obstacle    = ($urandom_range(0, 99) < pct);
      item.drain_first = drain_first && (i == 0);
      pending_cells.push_back(item);
    end
  endtask

  task automatic push_bits(input logic [31:0] bits, input int unsigned n);
    cell_item_t item;
    for (int unsigned i = 0; i < n; i++) begin
      item.obstacle    = bits[i];
      item.drain_first = 1'b0;
      pending_cells.push_back(item);
    end
  endtask

  initial begin
    int unsigned rand_cells, n, pct, k;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    rows_reg            = DimW'(1);
    cols_reg            = DimW'(1);
    for (int i = 0; i < MaxCols; i++) line_sizes[i] = '0;
    restart_scan();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset-size grid, zero sizes, full square, tie, abandoned grid
    push_bits(32'b10, 2);
    wait_idle();
    set_dim(REG_GRID_ROWS, '0);
    set_dim(REG_GRID_COLS, '0);
    push_bits(32'b0, 1);
    wait_idle();
    set_dim(REG_GRID_ROWS, DimW'(3));
    set_dim(REG_GRID_COLS, DimW'(3));
    push_bits(32'b0, 9);
    wait_idle();
    set_dim(REG_GRID_ROWS, DimW'(2));
    set_dim(REG_GRID_COLS, DimW'(4));
    push_bits(32'h11, 8);
    wait_idle();
    set_dim(REG_GRID_COLS, DimW'(2));
    push_bits(32'b100, 3);
    wait_idle();
    set_dim(REG_GRID_COLS, DimW'(2));
    push_bits(32'b0100, 4);
    wait_idle();

    // Long receiver hold-off on one-cell grids so the block backs up
    set_dim(REG_GRID_ROWS, DimW'(1));
    set_dim(REG_GRID_COLS, DimW'(1));
    @(negedge clk_i);
    hold_req++;
    push_cells(64, 50, 1'b0);
    wait_idle();

    // Widest grid, clamped: corner at the far column
    set_dim(REG_GRID_ROWS, DimW'(1));
    set_dim(REG_GRID_COLS, DimW'(2047));
    push_cells(MaxCols - 1, 100, 1'b1);
    push_cells(1, 0, 1'b0);
    wait_idle();
    set_dim(REG_GRID_ROWS, DimW'(8));
    set_dim(REG_GRID_COLS, DimW'(8));
    push_cells(8 * 8, 2, 1'b0);
    wait_idle();

    // Random grids of small size and varying density
    rand_cells = 0;
    while (rand_cells < RandCells) begin
      if (rand_cells > RandCells - 160) quiet = 1'b1;
      k = $urandom_range(0, 19);
      n = fold_dim(rows_reg, MaxRows) * fold_dim(cols_reg, MaxCols);
      if (k < 4) begin
        wait_idle();
        set_dim(REG_GRID_ROWS, DimW'($urandom_range(0, 9)));
        set_dim(REG_GRID_COLS, DimW'($urandom_range(0, 9)));
      end else if (k == 4 && n > 1) begin
        // Break off a grid part way and restart it with a register write
        n = $urandom_range(1, n - 1);
        push_cells(n, $urandom_range(0, 60), 1'b0);
        rand_cells += n;
        wait_idle();
        if ($urandom_range(0, 1)) set_dim(REG_GRID_ROWS, rows_reg);
        else set_dim(REG_GRID_COLS, cols_reg);
      end else begin
        case ($urandom_range(0, 5))
          0:       pct = 0;
          1:       pct = 5;
          2:       pct = 15;
          3:       pct = 30;
          4:       pct = 60;
          default: pct = 100;
        endcase
        push_cells(n, pct, $urandom_range(0, 9) == 0);
        rand_cells += n;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: largest_empty_square_finder.f
src/lesf_pkg.sv
src/lesf_if.sv
src/largest_empty_square_finder.sv
sim/largest_empty_square_finder_tb.sv
